[rtl/assert_macros.svh]
// Assertion macros included by the bell membership grade module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

[rtl/bmg_pkg.sv]
// Package with widths, constants and codes of the bell membership grade block.
package bmg_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CFG_BITS    = 24;
    localparam int SLOPE_BITS  = 16;
    localparam int GRADE_BITS  = 16;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam int MAG_BITS    = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;
    localparam int X_BITS      = MAG_BITS + 1;
    localparam int N_BITS      = $clog2(X_BITS);
    localparam int FRAC_BITS   = 16;
    localparam int LOG_BITS    = N_BITS + FRAC_BITS;
    localparam int Z_BITS      = 31;
    localparam int SQ_BITS     = 32;
    localparam int E_BITS      = CFG_BITS + SLOPE_BITS + 1;
    localparam int PROD_BITS   = E_BITS + LOG_BITS;
    localparam int M_SHIFT     = 20;
    localparam int M_BITS      = PROD_BITS - M_SHIFT;
    localparam int INT_BITS    = M_BITS - FRAC_BITS;
    localparam int IEXP_BITS   = 5;
    localparam int MAX_SHIFT   = 16;
    localparam int ACC_BITS    = 32;
    localparam int P_BITS      = ACC_BITS + MAX_SHIFT;
    localparam int DEN_BITS    = P_BITS + 1;
    localparam int NUM_BITS    = 64;
    localparam int Q_BITS      = 16;

    localparam logic [ACC_BITS-1:0] POLY_C1 = 32'd747394793;
    localparam logic [ACC_BITS-1:0] POLY_C2 = 32'd241048970;
    localparam logic [ACC_BITS-1:0] POLY_C3 = 32'd85298305;
    localparam logic [ACC_BITS-1:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [NUM_BITS-1:0] NUM_POS = 64'h0000_4000_0000_0000;

    localparam logic [GRADE_BITS-1:0] GRADE_ZERO = 16'h0000;
    localparam logic [GRADE_BITS-1:0] GRADE_HALF = 16'h8000;
    localparam logic [GRADE_BITS-1:0] GRADE_ONE  = 16'hFFFF;

    localparam int ST_IN    = 0;
    localparam int ST_ABS   = 1;
    localparam int ST_NORM  = 2;
    localparam int ST_LOG0  = 3;
    localparam int ST_LG    = ST_LOG0 + FRAC_BITS;
    localparam int ST_MUL   = ST_LG + 1;
    localparam int ST_P1    = ST_MUL + 1;
    localparam int ST_P2    = ST_P1 + 1;
    localparam int ST_P3    = ST_P2 + 1;
    localparam int ST_QD    = ST_P3 + 1;
    localparam int ST_DIV0  = ST_QD + 1;
    localparam int ST_LAST  = ST_DIV0 + Q_BITS - 1;
    localparam int NSTG     = ST_LAST + 1;

    typedef enum logic [1:0] {
        REG_CENTER = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_SLOPE  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_HALF,
        SPEC_ONE
    } spec_t;

endpackage

[rtl/bell_membership_grade.sv]
// Generalized bell membership grade: takes one signed Q11.12 sample per transaction and
// returns 1/(1+|(y-center)/(width/2)|^(2*width*slope)) as an unsigned Q0.16 grade. The
// pipeline takes one sample every cycle while its skid entry is empty; its depth is
// mostly set by the sixteen squaring stages of the two log2 units and the sixteen
// compare-and-subtract stages of the final divider. An output register with one skid
// entry lets a new sample in while a finished grade waits. Registers center, width and
// slope sit at byte addresses 0, 4 and 8 of the APB port; the user must write them only
// while no transaction is in flight, as the block itself does not enforce this.
module bell_membership_grade (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [bmg_pkg::ADDR_BITS-1:0]           paddr,
    input  logic [bmg_pkg::DATA_BITS-1:0]           pwdata,
    output logic [bmg_pkg::DATA_BITS-1:0]           prdata,
    output logic                                    pready,
    input  logic                                    sample_valid,
    output logic                                    sample_ready,
    input  logic signed [bmg_pkg::SAMPLE_BITS-1:0]  sample,
    output logic                                    grade_valid,
    input  logic                                    grade_ready,
    output logic [bmg_pkg::GRADE_BITS-1:0]          grade
);
    import bmg_pkg::*;

    `include "assert_macros.svh"

    function automatic logic [N_BITS-1:0] msb_pos(input logic [X_BITS-1:0] v);
        logic [N_BITS-1:0] pos;
        pos = '0;
        for (int b = 0; b < X_BITS; b++)
        begin
            if (v[b])
            begin
                pos = N_BITS'(b);
            end
        end
        return pos;
    endfunction

    function automatic logic [Z_BITS-1:0] norm(input logic [X_BITS-1:0] v,
                                               input logic [N_BITS-1:0] n);
        logic [X_BITS+Z_BITS-2:0] t;
        t = {v, {(Z_BITS-1){1'b0}}} >> n;
        return t[Z_BITS-1:0];
    endfunction

    function automatic logic [Z_BITS:0] sq_step(input logic [Z_BITS-1:0] z);
        logic [2*Z_BITS-1:0] p;
        logic [SQ_BITS-1:0]  s;
        p = (2*Z_BITS)'(z) * (2*Z_BITS)'(z);
        s = p[2*Z_BITS-1:Z_BITS-1];
        if (s[SQ_BITS-1])
        begin
            return {1'b1, s[SQ_BITS-1:1]};
        end
        return {1'b0, s[Z_BITS-1:0]};
    endfunction

    function automatic logic [ACC_BITS-1:0] poly_step(input logic [ACC_BITS-1:0]  c,
                                                      input logic [ACC_BITS-1:0]  acc,
                                                      input logic [FRAC_BITS-1:0] f);
        logic [ACC_BITS+FRAC_BITS-1:0] t;
        t = (ACC_BITS+FRAC_BITS)'(acc) * (ACC_BITS+FRAC_BITS)'(f);
        return c + t[ACC_BITS+FRAC_BITS-1:FRAC_BITS];
    endfunction

    logic signed [CFG_BITS-1:0]   center_reg;
    logic [CFG_BITS-1:0]          width_reg;
    logic [SLOPE_BITS-1:0]        slope_reg;
    logic [E_BITS-1:0]            e_reg;
    reg_idx_t                     reg_idx;
    logic                         cfg_wr;

    logic [NSTG-1:0]              vld_reg;
    spec_t                        spc_reg [NSTG];
    spec_t                        spc_next [NSTG];
    logic                         run;

    logic signed [MAG_BITS-1:0]   diff_reg;
    logic [MAG_BITS-1:0]          mag;
    logic [X_BITS-1:0]            x_reg;
    logic [X_BITS-1:0]            xw;
    logic [N_BITS-1:0]            na_pos;
    logic [N_BITS-1:0]            nb_pos;

    logic [Z_BITS-1:0]            za_reg [FRAC_BITS+1];
    logic [Z_BITS-1:0]            zb_reg [FRAC_BITS+1];
    logic [N_BITS-1:0]            na_reg [FRAC_BITS+1];
    logic [N_BITS-1:0]            nb_reg [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]         fa_reg [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]         fb_reg [FRAC_BITS+1];
    logic [Z_BITS:0]              sa_stp [FRAC_BITS];
    logic [Z_BITS:0]              sb_stp [FRAC_BITS];

    logic [LOG_BITS-1:0]          la;
    logic [LOG_BITS-1:0]          lb;
    logic [LOG_BITS-1:0]          lg_reg;
    logic                         lgn_reg;

    logic [PROD_BITS-1:0]         prod;
    logic [M_BITS-1:0]            mval;
    logic [INT_BITS-1:0]          mint;
    logic                         mbig;
    logic [FRAC_BITS-1:0]         mf_reg;
    logic [IEXP_BITS-1:0]         mi_reg;
    logic                         mneg_reg;

    logic [ACC_BITS-1:0]          pacc_reg [3];
    logic [FRAC_BITS-1:0]         pf_reg [2];
    logic [IEXP_BITS-1:0]         pi_reg [3];
    logic                         pn_reg [3];

    logic [P_BITS-1:0]            pw;
    logic [NUM_BITS-1:0]          rem_reg [Q_BITS+1];
    logic [DEN_BITS-1:0]          den_reg [Q_BITS+1];
    logic [Q_BITS-1:0]            quo_reg [Q_BITS+1];
    logic [NUM_BITS-1:0]          dsh [Q_BITS];
    logic                         dge [Q_BITS];

    logic [GRADE_BITS-1:0]        grade_new;
    logic                         out_vld_reg;
    logic [GRADE_BITS-1:0]        out_grade_reg;
    logic                         skd_vld_reg;
    logic [GRADE_BITS-1:0]        skd_grade_reg;
    logic                         take;
    logic                         inc;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            width_reg  <= CFG_BITS'(4096);
            slope_reg  <= SLOPE_BITS'(256);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CENTER: center_reg <= pwdata[CFG_BITS-1:0];
                REG_WIDTH:  width_reg  <= pwdata[CFG_BITS-1:0];
                REG_SLOPE:  slope_reg  <= pwdata[SLOPE_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER: prdata = DATA_BITS'(unsigned'(center_reg));
            REG_WIDTH:  prdata = DATA_BITS'(width_reg);
            REG_SLOPE:  prdata = DATA_BITS'(slope_reg);
            default:    prdata = '0;
        endcase
    end

    // The exponent depends on the registers only.
    always_ff @(posedge clk)
    begin
        e_reg <= {(E_BITS-1)'(width_reg) * (E_BITS-1)'(slope_reg), 1'b0};
    end

    assign run          = !skd_vld_reg;
    assign sample_ready = run;

    // Combinational part of the stages.
    always_comb
    begin
        mag    = diff_reg[MAG_BITS-1] ? unsigned'(-diff_reg) : unsigned'(diff_reg);
        xw     = X_BITS'(width_reg);
        na_pos = msb_pos(x_reg);
        nb_pos = msb_pos(xw);
        for (int j = 0; j < FRAC_BITS; j++)
        begin
            sa_stp[j] = sq_step(za_reg[j]);
            sb_stp[j] = sq_step(zb_reg[j]);
        end
        la   = {na_reg[FRAC_BITS], fa_reg[FRAC_BITS]};
        lb   = {nb_reg[FRAC_BITS], fb_reg[FRAC_BITS]};
        prod = PROD_BITS'(e_reg) * PROD_BITS'(lg_reg);
        mval = prod[PROD_BITS-1:M_SHIFT];
        mint = mval[M_BITS-1:FRAC_BITS];
        mbig = mint > INT_BITS'(MAX_SHIFT);
        pw   = P_BITS'(pacc_reg[2]) << pi_reg[2];
        for (int j = 0; j < Q_BITS; j++)
        begin
            dsh[j] = NUM_BITS'(den_reg[j]) << (Q_BITS - 1 - j);
            dge[j] = rem_reg[j] >= dsh[j];
        end
    end

    always_comb
    begin
        spc_next[ST_IN] = SPEC_NONE;
        for (int k = 1; k < NSTG; k++)
        begin
            spc_next[k] = spc_reg[k-1];
        end
        priority if (width_reg == '0)
        begin
            spc_next[ST_ABS] = SPEC_ZERO;
        end
        else if (slope_reg == '0)
        begin
            spc_next[ST_ABS] = SPEC_HALF;
        end
        else if (diff_reg == '0)
        begin
            spc_next[ST_ABS] = SPEC_ONE;
        end
        else
        begin
            spc_next[ST_ABS] = SPEC_NONE;
        end
        if (spc_reg[ST_LG] == SPEC_NONE && mbig)
        begin
            spc_next[ST_MUL] = lgn_reg ? SPEC_ONE : SPEC_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (run)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], sample_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                spc_reg[k] <= spc_next[k];
            end

            diff_reg <= MAG_BITS'(sample) - MAG_BITS'(center_reg);
            x_reg    <= {mag, 1'b0};

            na_reg[0] <= na_pos;
            nb_reg[0] <= nb_pos;
            za_reg[0] <= norm(x_reg, na_pos);
            zb_reg[0] <= norm(xw, nb_pos);
            fa_reg[0] <= '0;
            fb_reg[0] <= '0;
            for (int j = 0; j < FRAC_BITS; j++)
            begin
                za_reg[j+1] <= sa_stp[j][Z_BITS-1:0];
                zb_reg[j+1] <= sb_stp[j][Z_BITS-1:0];
                na_reg[j+1] <= na_reg[j];
                nb_reg[j+1] <= nb_reg[j];
                fa_reg[j+1] <= fa_reg[j]
                               | (FRAC_BITS'(sa_stp[j][Z_BITS]) << (FRAC_BITS - 1 - j));
                fb_reg[j+1] <= fb_reg[j]
                               | (FRAC_BITS'(sb_stp[j][Z_BITS]) << (FRAC_BITS - 1 - j));
            end

            lgn_reg <= la < lb;
            lg_reg  <= (la < lb) ? lb - la : la - lb;

            mf_reg   <= mval[FRAC_BITS-1:0];
            mi_reg   <= mint[IEXP_BITS-1:0];
            mneg_reg <= lgn_reg;

            pacc_reg[0] <= poly_step(POLY_C2, POLY_C3, mf_reg);
            pf_reg[0]   <= mf_reg;
            pi_reg[0]   <= mi_reg;
            pn_reg[0]   <= mneg_reg;
            pacc_reg[1] <= poly_step(POLY_C1, pacc_reg[0], pf_reg[0]);
            pf_reg[1]   <= pf_reg[0];
            pi_reg[1]   <= pi_reg[0];
            pn_reg[1]   <= pn_reg[0];
            pacc_reg[2] <= poly_step(ONE_Q30, pacc_reg[1], pf_reg[1]);
            pi_reg[2]   <= pi_reg[1];
            pn_reg[2]   <= pn_reg[1];

            rem_reg[0] <= pn_reg[2] ? {pw, {(NUM_BITS-P_BITS){1'b0}}} : NUM_POS;
            den_reg[0] <= DEN_BITS'(pw) + DEN_BITS'(ONE_Q30);
            quo_reg[0] <= '0;
            for (int j = 0; j < Q_BITS; j++)
            begin
                rem_reg[j+1] <= dge[j] ? rem_reg[j] - dsh[j] : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                quo_reg[j+1] <= quo_reg[j] | (Q_BITS'(dge[j]) << (Q_BITS - 1 - j));
            end
        end
    end

    // Output register with one skid entry.
    always_comb
    begin
        unique case (spc_reg[ST_LAST])
            SPEC_NONE: grade_new = quo_reg[Q_BITS];
            SPEC_ZERO: grade_new = GRADE_ZERO;
            SPEC_HALF: grade_new = GRADE_HALF;
            SPEC_ONE:  grade_new = GRADE_ONE;
            default:   grade_new = GRADE_ZERO;
        endcase
    end

    assign take        = out_vld_reg && grade_ready;
    assign inc         = run && vld_reg[ST_LAST];
    assign grade_valid = out_vld_reg;
    assign grade       = out_grade_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            skd_vld_reg <= 1'b0;
        end
        else if (take || !out_vld_reg)
        begin
            if (skd_vld_reg)
            begin
                out_vld_reg <= 1'b1;
                skd_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= inc;
            end
        end
        else if (inc)
        begin
            skd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_vld_reg)
        begin
            out_grade_reg <= skd_vld_reg ? skd_grade_reg : grade_new;
        end
        else if (inc)
        begin
            skd_grade_reg <= grade_new;
        end
    end

    `ASSERT_SAME(a_skid_behind_out, skd_vld_reg, out_vld_reg)
    `ASSERT_SAME(a_log_normalized, vld_reg[ST_NORM] && spc_reg[ST_NORM] == SPEC_NONE, za_reg[0][Z_BITS-1])
    `ASSERT_SAME(a_div_remainder, vld_reg[ST_LAST] && spc_reg[ST_LAST] == SPEC_NONE, rem_reg[Q_BITS] < NUM_BITS'(den_reg[Q_BITS]))
    `ASSERT_NEXT(a_stall_keeps_item, !run && vld_reg[ST_MUL], vld_reg[ST_MUL])

endmodule
